// ----- rtl/nfpe_pkg.sv -----
// ----------------------------------------------------------------------------
// nfpe_pkg
// Shared types and constants of the NOR flash program engine.
// ----------------------------------------------------------------------------
package nfpe_pkg;

  localparam int unsigned OffW  = 13;  // offset, length, capacity width
  localparam int unsigned DatW  = 8;   // byte width
  localparam int unsigned UnitW = 8;   // write unit width
  localparam int unsigned PosW  = 15;  // byte address reach, offset plus count
  localparam int unsigned RemSteps = PosW;

  localparam logic [7:0] ErasedByte = 8'hFF;

  localparam logic [2:0] OP_READ    = 3'd0;
  localparam logic [2:0] OP_WRITE   = 3'd1;
  localparam logic [2:0] OP_ERASE   = 3'd2;
  localparam logic [2:0] OP_PROGRAM = 3'd3;
  localparam logic [2:0] OP_CHECK   = 3'd4;

  localparam logic [0:0] REG_CAPACITY = 1'b0;
  localparam logic [0:0] REG_UNIT     = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_UNSUP   = 3'd2,
    ST_NOSPACE = 3'd3,
    ST_IO      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_CLR,
    B_IDLE,
    B_EXEC,
    B_RDW,
    B_LD,
    B_BR,
    B_PG,
    B_ST,
    B_OUT
  } back_state_e;

  // One classified byte transaction handed from the front to the back.
  typedef struct packed {
    logic [2:0]       op;
    logic [DatW-1:0]  data;
    logic             first;
    logic             final_item;
    logic             in_range;
    logic             last_byte;
    status_e          chk;
    logic [PosW-1:0]  pos;
    logic [UnitW-1:0] idx;
    logic [PosW-1:0]  base;
    logic [UnitW-1:0] unit;
  } item_t;

endpackage

// ----- rtl/nfpe_ram.sv -----
// ----------------------------------------------------------------------------
// nfpe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nfpe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH):1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH):1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/nfpe_rem.sv -----
// ----------------------------------------------------------------------------
// nfpe_rem
// Two-lane restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module nfpe_rem import nfpe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [PosW-1:0]  num_a_i,
  input  logic [PosW-1:0]  num_b_i,
  input  logic [UnitW-1:0] div_i,
  output logic             done_o,
  output logic [UnitW-1:0] rem_a_o,
  output logic [UnitW-1:0] rem_b_o
);

  logic [PosW-1:0]  qa_q, qa_d, qb_q, qb_d;
  logic [UnitW-1:0] ra_q, ra_d, rb_q, rb_d, div_q, div_d;
  logic [3:0]       step_q, step_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [UnitW:0]   ta, tb;

  always_comb begin
    ta = {ra_q, qa_q[PosW-1]};
    tb = {rb_q, qb_q[PosW-1]};
    if (ta >= {1'b0, div_q}) ta = ta - {1'b0, div_q};
    if (tb >= {1'b0, div_q}) tb = tb - {1'b0, div_q};
    qa_d = qa_q; qb_d = qb_q; ra_d = ra_q; rb_d = rb_q; div_d = div_q;
    step_d = step_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      qa_d = num_a_i; qb_d = num_b_i; ra_d = '0; rb_d = '0;
      div_d = div_i; step_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      qa_d = qa_q << 1;
      qb_d = qb_q << 1;
      ra_d = ta[UnitW-1:0];
      rb_d = tb[UnitW-1:0];
      step_d = step_q + 4'd1;
      if (step_q == 4'(RemSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qa_q <= qa_d; qb_q <= qb_d; ra_q <= ra_d; rb_q <= rb_d; div_q <= div_d;
  end

  assign done_o  = done_q;
  assign rem_a_o = ra_q;
  assign rem_b_o = rb_q;

endmodule

// ----- rtl/nfpe_queue.sv -----
// ----------------------------------------------------------------------------
// nfpe_queue
// Two-entry queue of classified transactions between front and back.
// ----------------------------------------------------------------------------
module nfpe_queue import nfpe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t item_o
);

  item_t      slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wp_q] <= item_i;
  end

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign item_o  = slot_q[rp_q];

endmodule

// ----- rtl/nfpe_front.sv -----
// ----------------------------------------------------------------------------
// nfpe_front
// Accepts byte transactions, tracks the byte position, runs the command
// checks and the unit position, and queues the classified transaction.
// ----------------------------------------------------------------------------
module nfpe_front import nfpe_pkg::*; #(
  parameter int unsigned CAPACITY = 4096,
  parameter int unsigned MAX_UNIT = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       op_i,
  input  logic [OffW-1:0]  offset_i,
  input  logic [OffW-1:0]  length_i,
  input  logic [DatW-1:0]  data_byte_i,
  input  logic [OffW-1:0]  cap_i,
  input  logic [UnitW-1:0] unit_i,
  input  logic             clear_busy_i,
  input  logic             q_full_i,
  output logic             push_o,
  output item_t            item_o
);

  localparam logic [OffW-1:0] CapClamp = OffW'(CAPACITY);

  front_state_e fs_q, fs_d;

  logic [OffW-1:0]  k_q, k_d;
  logic [2:0]       op_q;
  logic [OffW-1:0]  off_q, len_q, kh_q;
  logic [DatW-1:0]  dat_q;
  logic [UnitW-1:0] u_q;
  logic             first_q, final_q, hit_q, prog_q;
  logic             trk_v_q, trk_v_d;
  logic [OffW-1:0]  trk_off_q;
  logic [UnitW-1:0] trk_u_q, trk_idx_q;
  logic [PosW-1:0]  trk_base_q;

  logic             accept, first, final_now, unit_ok, track_hit, need_chk, need_idx;
  logic [OffW-1:0]  eff_cap, total;
  logic [UnitW-1:0] u;
  logic [PosW-1:0]  pos_h;
  logic [UnitW-1:0] idx, idx_inc, rem_a, rem_b;
  logic [PosW:0]    rounded;
  logic             rem_done;
  status_e          chk;

  assign eff_cap = (32'(cap_i) < CAPACITY) ? cap_i : CapClamp;
  assign u       = (unit_i == '0) ? UnitW'(1) : unit_i;
  assign unit_ok = (u > UnitW'(1)) && (32'(u) <= MAX_UNIT);

  assign in_stall_o = (fs_q != F_IDLE) || clear_busy_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign first      = k_q == '0;
  assign total      = (length_i == '0) ? OffW'(1) : length_i;
  assign final_now  = ({1'b0, k_q} + 14'd1) >= {1'b0, total};
  assign track_hit  = trk_v_q && !first && (offset_i == trk_off_q) && (u == trk_u_q);
  assign need_chk   = first && (op_i == OP_PROGRAM) && (length_i != '0) && unit_ok;
  assign need_idx   = (op_i == OP_PROGRAM) && unit_ok && !track_hit;

  nfpe_rem u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && (need_chk || need_idx)),
    .num_a_i (PosW'(offset_i) + PosW'(k_q)),
    .num_b_i (PosW'(offset_i) + PosW'(length_i)),
    .div_i   (u),
    .done_o  (rem_done),
    .rem_a_o (rem_a),
    .rem_b_o (rem_b)
  );

  always_comb begin
    fs_d = fs_q;
    case (fs_q)
      F_IDLE: begin
        if (accept) fs_d = (need_chk || need_idx) ? F_DIV : F_PUSH;
      end
      F_DIV: begin
        if (rem_done) fs_d = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full_i) fs_d = F_IDLE;
      end
      default: fs_d = F_IDLE;
    endcase
  end

  always_comb begin
    pos_h   = PosW'(off_q) + PosW'(kh_q);
    idx_inc = ({1'b0, trk_idx_q} + 9'd1 == {1'b0, u_q}) ? '0 : trk_idx_q + UnitW'(1);
    idx     = prog_q ? (hit_q ? idx_inc : rem_a) : '0;
    rounded = {1'b0, PosW'(off_q) + PosW'(len_q)} +
              ((rem_b != '0) ? (PosW+1)'(u_q - rem_b) : '0);
    if (op_q > OP_CHECK) begin
      chk = ST_UNSUP;
    end else if (off_q > eff_cap || len_q > eff_cap - off_q) begin
      chk = ST_RANGE;
    end else if (op_q == OP_PROGRAM && len_q != '0 && 32'(u_q) > MAX_UNIT) begin
      chk = ST_UNSUP;
    end else if (op_q == OP_PROGRAM && len_q != '0 && u_q > UnitW'(1) &&
                 rounded > (PosW+1)'(eff_cap)) begin
      chk = ST_NOSPACE;
    end else begin
      chk = ST_OK;
    end
    push_o = (fs_q == F_PUSH) && !q_full_i;
    item_o.op         = op_q;
    item_o.data       = dat_q;
    item_o.first      = first_q;
    item_o.final_item = final_q;
    item_o.in_range   = (kh_q < len_q) && (pos_h < PosW'(eff_cap));
    item_o.last_byte  = ({1'b0, kh_q} + 14'd1) >= {1'b0, len_q};
    item_o.chk        = chk;
    item_o.pos        = pos_h;
    item_o.idx        = idx;
    item_o.base       = pos_h - PosW'(idx);
    item_o.unit       = u_q;
    k_d     = accept ? (final_now ? '0 : k_q + OffW'(1)) : k_q;
    trk_v_d = push_o ? prog_q : trk_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q    <= F_IDLE;
      k_q     <= '0;
      trk_v_q <= 1'b0;
    end else begin
      fs_q    <= fs_d;
      k_q     <= k_d;
      trk_v_q <= trk_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_i;
      off_q   <= offset_i;
      len_q   <= length_i;
      dat_q   <= data_byte_i;
      kh_q    <= k_q;
      u_q     <= u;
      first_q <= first;
      final_q <= final_now;
      hit_q   <= track_hit;
      prog_q  <= (op_i == OP_PROGRAM) && unit_ok;
    end
    if (push_o) begin
      trk_off_q  <= off_q;
      trk_u_q    <= u_q;
      trk_idx_q  <= idx;
      trk_base_q <= item_o.base;
    end
  end

  // The tracked unit start always sits on a unit boundary below the position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && prog_q && hit_q) |-> (trk_idx_q < trk_u_q && item_o.pos >= trk_base_q))
    else $error("nfpe_front: unit tracking out of step");

endmodule

// ----- rtl/nfpe_back.sv -----
// ----------------------------------------------------------------------------
// nfpe_back
// Carries out queued transactions on the flash store and the unit buffer,
// and holds the result register.
// ----------------------------------------------------------------------------
module nfpe_back import nfpe_pkg::*; #(
  parameter int unsigned CAPACITY = 4096,
  parameter int unsigned MAX_UNIT = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  item_t           q_item_i,
  output logic            pop_o,
  output logic            clear_busy_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [DatW-1:0] read_data_o,
  output logic [2:0]      status_o,
  output logic            is_erased_o,
  output logic            done_res_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned BW = (MAX_UNIT > 1) ? $clog2(MAX_UNIT) : 1;
  localparam int unsigned CW = $clog2(MAX_UNIT + 1);

  back_state_e bs_q, bs_d;
  item_t       it_q, it_d;
  status_e     st_q, st_d;
  logic        ae_q, ae_d, uc_q, uc_d, oob_q, oob_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [DatW-1:0] rd_q, rd_d;
  logic        ov_q, ov_d, oe_q, oe_d, odone_q, odone_d;
  logic [DatW-1:0] ord_q, ord_d;
  logic [2:0]  ost_q, ost_d;

  logic            f_we, f_re, b_we, b_re;
  logic [AW-1:0]   f_waddr, f_raddr;
  logic [DatW-1:0] f_wdata, f_rdata, b_wdata, b_rdata, prog;
  logic [BW-1:0]   b_waddr, b_raddr;
  logic [PosW-1:0] ld_addr, st_addr;
  logic [CW-1:0]   n;
  logic            act, chg, out_free;

  nfpe_ram #(.WIDTH(DatW), .DEPTH(CAPACITY)) u_flash (
    .clk_i(clk_i), .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .re_i(f_re), .raddr_i(f_raddr), .rdata_o(f_rdata)
  );

  nfpe_ram #(.WIDTH(DatW), .DEPTH(MAX_UNIT)) u_ubuf (
    .clk_i(clk_i), .we_i(b_we), .waddr_i(b_waddr), .wdata_i(b_wdata),
    .re_i(b_re), .raddr_i(b_raddr), .rdata_o(b_rdata)
  );

  assign n        = CW'(it_q.unit);
  assign ld_addr  = it_q.base + PosW'(cnt_q);
  assign st_addr  = it_q.base + PosW'(cnt_q) - PosW'(1);
  assign act      = (st_q == ST_OK) && it_q.in_range;
  assign prog     = b_rdata & it_q.data;
  assign chg      = prog != b_rdata;
  assign out_free = !ov_q || !out_stall_i;

  // Next state.
  always_comb begin
    bs_d = bs_q;
    case (bs_q)
      B_CLR:  if (32'(clr_q) == CAPACITY - 1) bs_d = B_IDLE;
      B_IDLE: if (!q_empty_i) bs_d = B_EXEC;
      B_EXEC: begin
        bs_d = B_OUT;
        if (act) begin
          case (it_q.op)
            OP_READ, OP_CHECK: bs_d = B_RDW;
            OP_PROGRAM: begin
              if (it_q.unit != UnitW'(1) && 32'(it_q.unit) <= MAX_UNIT) begin
                bs_d = (it_q.first || it_q.idx == '0) ? B_LD : B_BR;
              end
            end
            default: bs_d = B_OUT;
          endcase
        end
      end
      B_RDW: bs_d = B_OUT;
      B_LD:  if (cnt_q == n) bs_d = B_BR;
      B_BR:  bs_d = B_PG;
      B_PG: begin
        bs_d = B_OUT;
        if ((~b_rdata & it_q.data) == '0 &&
            ({1'b0, it_q.idx} + 9'd1 == {1'b0, it_q.unit} || it_q.last_byte) &&
            (uc_q || chg)) begin
          bs_d = B_ST;
        end
      end
      B_ST:  if (cnt_q == n) bs_d = B_OUT;
      B_OUT: if (out_free) bs_d = B_IDLE;
      default: bs_d = B_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    it_d = it_q; st_d = st_q; ae_d = ae_q; uc_d = uc_q; cnt_d = cnt_q;
    clr_d = clr_q; rd_d = rd_q; oob_d = oob_q;
    ov_d = ov_q && out_stall_i; ord_d = ord_q; ost_d = ost_q;
    oe_d = oe_q; odone_d = odone_q;
    f_we = 1'b0; f_waddr = AW'(it_q.pos); f_wdata = it_q.data;
    f_re = 1'b0; f_raddr = AW'(it_q.pos);
    b_we = 1'b0; b_waddr = it_q.idx[BW-1:0]; b_wdata = prog;
    b_re = 1'b0; b_raddr = it_q.idx[BW-1:0];
    pop_o = 1'b0;
    case (bs_q)
      B_CLR: begin
        f_we = 1'b1; f_waddr = clr_q; f_wdata = ErasedByte;
        clr_d = clr_q + AW'(1);
      end
      B_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          it_d = q_item_i;
          if (q_item_i.first) begin
            st_d = q_item_i.chk; ae_d = 1'b1; uc_d = 1'b0;
          end
        end
      end
      B_EXEC: begin
        rd_d = '0;
        cnt_d = '0;
        if (act) begin
          case (it_q.op)
            OP_READ, OP_CHECK: f_re = 1'b1;
            OP_WRITE: f_we = 1'b1;
            OP_ERASE: begin
              f_we = 1'b1; f_wdata = ErasedByte;
            end
            OP_PROGRAM: begin
              if (it_q.unit == UnitW'(1)) begin
                f_we = 1'b1;
              end else if (32'(it_q.unit) > MAX_UNIT) begin
                st_d = ST_UNSUP;
              end else if (it_q.first || it_q.idx == '0) begin
                uc_d = 1'b0;
              end
            end
            default: rd_d = '0;
          endcase
        end
      end
      B_RDW: begin
        if (it_q.op == OP_READ) rd_d = f_rdata;
        if (it_q.op == OP_CHECK && f_rdata != ErasedByte) ae_d = 1'b0;
      end
      B_LD: begin
        f_re = cnt_q != n;
        f_raddr = AW'(ld_addr);
        oob_d = !(32'(ld_addr) < CAPACITY);
        if (cnt_q != '0) begin
          b_we = 1'b1;
          b_waddr = BW'(cnt_q - CW'(1));
          b_wdata = oob_q ? '0 : f_rdata;
        end
        cnt_d = (cnt_q == n) ? '0 : cnt_q + CW'(1);
      end
      B_BR: b_re = 1'b1;
      B_PG: begin
        if ((~b_rdata & it_q.data) != '0) begin
          st_d = ST_IO; uc_d = 1'b0;
        end else begin
          b_we = chg;
          if ({1'b0, it_q.idx} + 9'd1 == {1'b0, it_q.unit} || it_q.last_byte) begin
            uc_d = 1'b0;
          end else begin
            uc_d = uc_q || chg;
          end
        end
        cnt_d = '0;
      end
      B_ST: begin
        b_re = cnt_q != n;
        b_raddr = cnt_q[BW-1:0];
        if (cnt_q != '0 && 32'(st_addr) < CAPACITY) begin
          f_we = 1'b1; f_waddr = AW'(st_addr); f_wdata = b_rdata;
        end
        cnt_d = cnt_q + CW'(1);
      end
      B_OUT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ord_d   = (st_q == ST_OK) ? rd_q : '0;
          ost_d   = st_q;
          oe_d    = it_q.final_item && it_q.op == OP_CHECK && st_q == ST_OK && ae_q;
          odone_d = it_q.final_item;
        end
      end
      default: pop_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q  <= B_CLR;
      st_q  <= ST_OK;
      ae_q  <= 1'b1;
      uc_q  <= 1'b0;
      cnt_q <= '0;
      clr_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      bs_q  <= bs_d;
      st_q  <= st_d;
      ae_q  <= ae_d;
      uc_q  <= uc_d;
      cnt_q <= cnt_d;
      clr_q <= clr_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d; rd_q <= rd_d; oob_q <= oob_d;
    ord_q <= ord_d; ost_q <= ost_d; oe_q <= oe_d; odone_q <= odone_d;
  end

  assign clear_busy_o = bs_q == B_CLR;
  assign out_valid_o  = ov_q;
  assign read_data_o  = ord_q;
  assign status_o     = ost_q;
  assign is_erased_o  = oe_q;
  assign done_res_o   = odone_q;

  // Nothing leaves the queue while the store is still being erased after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bs_q == B_CLR) |-> !pop_o)
    else $error("nfpe_back: pop during clearing pass");

  // A write-back sweep only starts for a unit that holds a change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bs_q == B_PG && bs_d == B_ST) |-> (uc_q || chg))
    else $error("nfpe_back: write-back of an unchanged unit");

  // After an I/O abort the flash store is not touched for the same command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IO && bs_q != B_IDLE && bs_q != B_CLR) |-> !f_we)
    else $error("nfpe_back: flash write after abort");

endmodule

// ----- rtl/nor_flash_program_engine_unit.sv -----
// ----------------------------------------------------------------------------
// nor_flash_program_engine_unit
// Byte-streamed flash store emulation with NOR-style unit programming.
// ----------------------------------------------------------------------------
// A command arrives as max(length,1) byte transactions, each repeating op,
// offset and length, and each transaction returns exactly one result; the
// last one carries done_res and the final status. After reset the block
// erases its store to 0xFF, one byte a cycle, and stalls its input during
// that sweep. A read or erased-check makes one flash read per byte. A
// program with a larger unit also reads and updates its buffer entry, loads
// the unit into the buffer at each unit start, and writes it back when it
// changed; the position within the unit is found by a remainder unit on the
// first byte of a command and whenever offset or unit size differs from the
// previous byte, and advances by one otherwise. The front stage classifies
// the next transaction while the back stage works, with a two-entry queue
// between, and a result register lets a finished transaction wait while the
// next one is carried out.
// ----------------------------------------------------------------------------
module nor_flash_program_engine_unit import nfpe_pkg::*; #(
  parameter int unsigned CAPACITY = 4096,
  parameter int unsigned MAX_UNIT = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [2:0]      op_i,
  input  logic [OffW-1:0] offset_i,
  input  logic [OffW-1:0] length_i,
  input  logic [DatW-1:0] data_byte_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [DatW-1:0] read_data_o,
  output logic [2:0]      status_o,
  output logic            is_erased_o,
  output logic            done_res_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  // Configuration registers; capacity resets to the full 4 KiB view.
  logic [OffW-1:0]  cap_q;
  logic [UnitW-1:0] unit_q;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= 13'd4096;
      unit_q <= 8'd1;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_CAPACITY: cap_q <= pwdata[OffW-1:0];
        REG_UNIT:     unit_q <= pwdata[UnitW-1:0];
        default:      unit_q <= unit_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CAPACITY: prdata = {19'b0, cap_q};
      REG_UNIT:     prdata = {24'b0, unit_q};
      default:      prdata = '0;
    endcase
  end

  // Front and back are joined by a short queue so each can stall on its own.
  item_t f_item, q_item;
  logic  push, pop, q_full, q_empty, clear_busy;

  nfpe_front #(.CAPACITY(CAPACITY), .MAX_UNIT(MAX_UNIT)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .offset_i     (offset_i),
    .length_i     (length_i),
    .data_byte_i  (data_byte_i),
    .cap_i        (cap_q),
    .unit_i       (unit_q),
    .clear_busy_i (clear_busy),
    .q_full_i     (q_full),
    .push_o       (push),
    .item_o       (f_item)
  );

  nfpe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .item_o  (q_item)
  );

  nfpe_back #(.CAPACITY(CAPACITY), .MAX_UNIT(MAX_UNIT)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_item_i     (q_item),
    .pop_o        (pop),
    .clear_busy_o (clear_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .status_o     (status_o),
    .is_erased_o  (is_erased_o),
    .done_res_o   (done_res_o)
  );

  // The queue is never written when full nor read when empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_full) && !(pop && q_empty))
    else $error("nor_flash_program_engine_unit: queue overrun");

  // No transaction is taken while the store is still being erased.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy |-> in_stall_o)
    else $error("nor_flash_program_engine_unit: input taken during clearing");

  // Results other than the last of a command never report an erased range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !done_res_o) |-> !is_erased_o)
    else $error("nor_flash_program_engine_unit: erased flag before command end");

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking testbench of the NOR flash program engine.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the flash store and the command state.
// It works out the expected result of every accepted byte transaction and
// compares each delivered result with the oldest expectation. The stimulus
// first covers the corner cases directly. It then streams random commands
// under several capacity and unit settings, with random idling on both
// sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import nfpe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Capacity = 4096;
  localparam int unsigned MaxUnit  = 8;
  localparam int unsigned Limit    = 1000000;
  localparam int unsigned Settle   = 200;

  typedef struct {
    logic [DatW-1:0] read_data;
    logic [2:0]      status;
    logic            is_erased;
    logic            done_res;
  } flash_result_t;

  // The scoreboard mirrors the engine: store, unit buffer and per-command state.
  class flash_scoreboard;
    logic [DatW-1:0] store_mem [Capacity];
    logic [DatW-1:0] unit_buf [MaxUnit];
    int unsigned     byte_pos;
    status_e         cmd_status;
    bit              unit_dirty;
    bit              all_ff;
    int unsigned     capacity_reg;
    int unsigned     unit_reg;
    int unsigned     fails;
    flash_result_t   expected_q [$];

    function new();
      foreach (store_mem[i]) store_mem[i] = ErasedByte;
      foreach (unit_buf[i]) unit_buf[i] = '0;
      byte_pos = 0;
      cmd_status = ST_OK;
      unit_dirty = 0;
      all_ff = 1;
      capacity_reg = Capacity;
      unit_reg = 1;
      fails = 0;
    endfunction

    function int unsigned usable_bytes();
      return (capacity_reg < Capacity) ? capacity_reg : Capacity;
    endfunction

    function int unsigned unit_bytes();
      return (unit_reg == 0) ? 1 : unit_reg;
    endfunction

    function status_e command_check(logic [2:0] op, int unsigned off, int unsigned len);
      int unsigned cap;
      int unsigned u;
      cap = usable_bytes();
      u = unit_bytes();
      if (op > OP_CHECK) return ST_UNSUP;
      if (off > cap || len > cap - off) return ST_RANGE;
      if (op == OP_PROGRAM && len != 0) begin
        if (u > MaxUnit) return ST_UNSUP;
        if (u > 1 && ((off + len + u - 1) / u) * u > cap) return ST_NOSPACE;
      end
      return ST_OK;
    endfunction

    // NOR programming: bits may only go from one to zero, unit by unit.
    function void program_byte(int unsigned p, logic [DatW-1:0] d, bit first, bit last_byte);
      int unsigned u;
      int unsigned idx;
      int unsigned base;
      logic [DatW-1:0] old;
      u = unit_bytes();
      if (u == 1) begin
        store_mem[p] = d;
        return;
      end
      if (u > MaxUnit) begin
        cmd_status = ST_UNSUP;
        return;
      end
      idx = p % u;
      base = p - idx;
      if (first || idx == 0) begin
        for (int i = 0; i < u; i++)
          unit_buf[i] = (base + i < Capacity) ? store_mem[base + i] : '0;
        unit_dirty = 0;
      end
      old = unit_buf[idx];
      if ((~old & d) != 0) begin
        cmd_status = ST_IO;
        unit_dirty = 0;
        return;
      end
      if ((old & d) != old) begin
        unit_buf[idx] = old & d;
        unit_dirty = 1;
      end
      if (idx == u - 1 || last_byte) begin
        if (unit_dirty)
          for (int i = 0; i < u; i++)
            if (base + i < Capacity) store_mem[base + i] = unit_buf[i];
        unit_dirty = 0;
      end
    endfunction

    function void note_transaction(logic [2:0] op, int unsigned off, int unsigned len,
                                   logic [DatW-1:0] d);
      int unsigned k;
      int unsigned p;
      bit first;
      bit last_item;
      bit active;
      flash_result_t r;
      k = byte_pos;
      first = (k == 0);
      last_item = (k + 1 >= ((len != 0) ? len : 1));
      p = off + k;
      r.read_data = '0;
      if (first) begin
        cmd_status = command_check(op, off, len);
        all_ff = 1;
        unit_dirty = 0;
      end
      active = (cmd_status == ST_OK) && (k < len) && (p < usable_bytes());
      if (active) begin
        case (op)
          OP_READ:    r.read_data = store_mem[p];
          OP_WRITE:   store_mem[p] = d;
          OP_ERASE:   store_mem[p] = ErasedByte;
          OP_PROGRAM: program_byte(p, d, first, k + 1 >= len);
          OP_CHECK:   if (store_mem[p] != ErasedByte) all_ff = 0;
          default: ;
        endcase
      end
      if (cmd_status != ST_OK) r.read_data = '0;
      r.status = cmd_status;
      r.is_erased = last_item && op == OP_CHECK && cmd_status == ST_OK && all_ff;
      r.done_res = last_item;
      expected_q.push_back(r);
      byte_pos = last_item ? 0 : ((k + 1) & 13'h1fff);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      fails++;
      $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    task check_result(flash_result_t got);
      flash_result_t want;
      if (expected_q.size() == 0) begin
        report("result with nothing pending", 1, 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.read_data !== want.read_data) report("read_data", got.read_data, want.read_data);
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.is_erased !== want.is_erased) report("is_erased", got.is_erased, want.is_erased);
      if (got.done_res !== want.done_res) report("done_res", got.done_res, want.done_res);
    endtask
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  logic [2:0]      op_i;
  logic [OffW-1:0] offset_i;
  logic [OffW-1:0] length_i;
  logic [DatW-1:0] data_byte_i;
  logic            out_valid_o;
  logic            out_stall_i;
  logic [DatW-1:0] read_data_o;
  logic [2:0]      status_o;
  logic            is_erased_o;
  logic            done_res_o;
  logic            psel;
  logic            penable;
  logic            pwrite;
  logic [2:0]      paddr;
  logic [31:0]     pwdata;
  logic [31:0]     prdata;
  logic            pready;

  flash_scoreboard sb = new();

  // Idling controls for the sender and the receiver, plus run counters.
  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          hold_request;
  int unsigned hold_left;
  int unsigned rx_burst_left;
  int unsigned cycle_count;
  int unsigned sent_items;

  nor_flash_program_engine_unit #(
    .CAPACITY(Capacity),
    .MAX_UNIT(MaxUnit)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .op_i(op_i),
    .offset_i(offset_i),
    .length_i(length_i),
    .data_byte_i(data_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .read_data_o(read_data_o),
    .status_o(status_o),
    .is_erased_o(is_erased_o),
    .done_res_o(done_res_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Watchdog: the run may not exceed the cycle limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= Limit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Receiver: check every accepted result, then choose the next stall value.
  // A long hold-off, once requested, lets the engine fill up and stall its input.
  always @(posedge clk_i) begin
    flash_result_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.read_data = read_data_o;
        got.status = status_o;
        got.is_erased = is_erased_o;
        got.done_res = done_res_o;
        sb.check_result(got);
      end
      if (hold_request) begin
        hold_request = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_burst_left > 0) begin
        rx_burst_left--;
        out_stall_i <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        rx_burst_left = $urandom_range(0, 15);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one byte transaction and wait until the engine takes it.
  task send_item(logic [2:0] op, int unsigned off, int unsigned len, logic [DatW-1:0] d);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    offset_i <= off[OffW-1:0];
    length_i <= len[OffW-1:0];
    data_byte_i <= d;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_transaction(op, off[OffW-1:0], len[OffW-1:0], d);
    sent_items++;
  endtask

  // A whole well-formed command: max(length,1) transactions with fixed fields.
  task send_command(logic [2:0] op, int unsigned off, int unsigned len, bit random_data,
                    logic [DatW-1:0] d);
    int unsigned n;
    n = (len != 0) ? len : 1;
    for (int unsigned i = 0; i < n; i++)
      send_item(op, off, len, random_data ? 8'($urandom_range(0, 255)) : d);
  endtask

  // Wait until every expected result has arrived and the engine has settled.
  task drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task reg_write(logic [0:0] idx, int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_CAPACITY) sb.capacity_reg = value & 13'h1fff;
    else sb.unit_reg = value & 8'hff;
  endtask

  task configure(int unsigned cap, int unsigned unit);
    drain();
    reg_write(REG_CAPACITY, cap);
    reg_write(REG_UNIT, unit);
  endtask

  // One random command. Addresses cluster near both ends of the usable range
  // so that reads and checks see earlier writes. A few commands are broken:
  // an opening transaction with a length of 4096 or more, then a short length
  // that ends the command early.
  task random_command();
    int unsigned cap;
    int unsigned off;
    int unsigned len;
    int unsigned pick;
    logic [2:0]  op;
    cap = sb.usable_bytes();
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_item(3'($urandom_range(0, 7)), $urandom_range(0, 8191), $urandom_range(4096, 8191),
                8'($urandom_range(0, 255)));
      send_item(3'($urandom_range(0, 7)), $urandom_range(0, 8191), $urandom_range(0, 1),
                8'($urandom_range(0, 255)));
      return;
    end
    op = (pick < 10) ? 3'($urandom_range(OP_CHECK + 1, 7)) : 3'($urandom_range(0, 4));
    if (pick >= 96) begin
      off = $urandom_range(0, 8191);
      len = $urandom_range(0, 6);
    end else begin
      off = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40)
                                        : cap - ((cap < 40) ? cap : $urandom_range(0, 40));
      if (off > cap) off = cap;
      len = $urandom_range(0, 12);
      if (len > cap - off && $urandom_range(0, 3) != 0) len = cap - off;
    end
    if (op == OP_PROGRAM && $urandom_range(0, 1) == 0) begin
      // Clearing bits only: program a random mask into freshly erased bytes.
      send_command(OP_ERASE, off, len, 0, 8'h00);
      send_command(OP_PROGRAM, off, len, 1, 8'h00);
    end else begin
      send_command(op, off, len, 1, 8'h00);
    end
  endtask

  initial begin
    int unsigned cap_choices [6] = '{4096, 16, 0, 4095, 8191, 100};
    int unsigned unit_choices [10] = '{1, 0, 2, 4, 8, 3, 7, 9, 255, 5};
    int unsigned phase;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = OP_READ;
    offset_i = '0;
    length_i = '0;
    data_byte_i = '0;
    out_stall_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_idle_on = 0;
    rx_idle_on = 0;
    hold_request = 0;
    hold_left = 0;
    rx_burst_left = 0;
    cycle_count = 0;
    sent_items = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: extremes of the fields, every op, every error status.
    configure(4096, 1);
    send_command(OP_READ, 0, 1, 0, 8'h00);
    send_command(OP_CHECK, 0, 0, 0, 8'h00);
    send_command(OP_WRITE, 4094, 2, 0, 8'h00);
    send_command(OP_READ, 4094, 2, 0, 8'h00);
    send_command(OP_ERASE, 4095, 1, 0, 8'h00);
    send_command(OP_PROGRAM, 10, 1, 0, 8'h5A);
    send_command(OP_CHECK, 8, 4, 0, 8'h00);
    send_command(3'd7, 0, 1, 0, 8'hFF);
    send_command(OP_READ, 4096, 1, 0, 8'h00);
    send_command(OP_READ, 8191, 0, 0, 8'h00);
    send_command(OP_PROGRAM, 0, 0, 0, 8'h00);
    configure(4096, 4);
    send_command(OP_PROGRAM, 0, 2, 0, 8'hAA);
    send_command(OP_PROGRAM, 1, 1, 0, 8'h55);
    send_command(OP_PROGRAM, 4094, 1, 0, 8'h0F);
    configure(4094, 4);
    send_command(OP_PROGRAM, 4090, 3, 0, 8'h00);
    configure(4096, 9);
    send_command(OP_PROGRAM, 0, 1, 0, 8'h00);
    configure(0, 0);
    send_command(OP_WRITE, 0, 1, 0, 8'h00);
    send_command(OP_CHECK, 0, 0, 0, 8'h00);

    // Random part, one setting after another; the last stretch runs flat out.
    tx_idle_on = 1;
    rx_idle_on = 1;
    phase = 0;
    while (sent_items < 1800) begin
      if (phase < 8) configure(cap_choices[$urandom_range(0, 5)],
                               unit_choices[$urandom_range(0, 9)]);
      else if (phase == 8) configure(4096, 8);
      else configure($urandom_range(0, 8191), $urandom_range(0, 255));
      if (phase == 3) hold_request = 1;
      if (phase >= 10) begin
        tx_idle_on = 0;
        rx_idle_on = 0;
      end
      repeat (20) random_command();
      phase++;
      if (phase > 11 && sent_items > 1700) phase = 10;
    end

    drain();
    if (sb.fails == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
